// ----- src/bank_switch_mapper_with_scanline_irq_macros.svh -----
// ----------------------------------------------------------------------------
// bank switch mapper assertion macros
// shorthand for clocked implication checks, reset-qualified
// ----------------------------------------------------------------------------
`ifndef BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_MACROS_SVH
`define BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_MACROS_SVH

// same-cycle implication
`define BSM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bsm_pkg.sv -----
// ----------------------------------------------------------------------------
// bsm_pkg
// shared types and codes of the bank switch mapper
// ----------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

    // input operations
    localparam logic [2:0] OP_CPU_READ  = 3'd0;
    localparam logic [2:0] OP_CPU_WRITE = 3'd1;
    localparam logic [2:0] OP_PPU_READ  = 3'd2;
    localparam logic [2:0] OP_PPU_WRITE = 3'd3;
    localparam logic [2:0] OP_PPU_TICK  = 3'd4;

    // result targets
    localparam logic [2:0] TGT_NONE     = 3'd0;
    localparam logic [2:0] TGT_PRG_RAM  = 3'd1;
    localparam logic [2:0] TGT_PRG_ROM  = 3'd2;
    localparam logic [2:0] TGT_CHR      = 3'd3;
    localparam logic [2:0] TGT_NAMETAB  = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_PRG_COUNT   = 3'd0;
    localparam logic [2:0] CFG_CHR_COUNT   = 3'd1;
    localparam logic [2:0] CFG_DEFAULT_HOR = 3'd2;
    localparam logic [2:0] CFG_CHR_WRITE   = 3'd3;
    localparam logic [2:0] CFG_EDGE_GAP    = 3'd4;

    // cpu register regions, address bits 14:13
    localparam logic [1:0] REG_BANK   = 2'd0;
    localparam logic [1:0] REG_MIRROR = 2'd1;
    localparam logic [1:0] REG_LATCH  = 2'd2;
    localparam logic [1:0] REG_IRQ_EN = 2'd3;

    // configuration reset values
    localparam logic [6:0] PRG_COUNT_RST   = 7'd8;
    localparam logic [8:0] CHR_COUNT_RST   = 9'd8;
    localparam logic       DEFAULT_HOR_RST = 1'b1;
    localparam logic [7:0] EDGE_GAP_RST    = 8'd9;

    // restoring remainder, one bit per step
    localparam int         MOD_STEPS = 8;
    localparam int         STEP_W    = $clog2(MOD_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MOD_STEPS - 1);

    localparam int ADDR_W   = 16;
    localparam int MAPPED_W = 19;
    localparam int CFG_W    = 9;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_MOD  = 2'b10
    } t_state;

endpackage

`default_nettype wire

// ----- src/bank_switch_mapper_with_scanline_irq.sv -----
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_scanline_irq
// cartridge bank mapper with a12 edge driven scanline irq counter
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        sink       i_in_valid / o_in_ready   i_op, i_address, i_data
//  out       source     o_out_valid / i_out_ready target, mapped address, flags
//  cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  most items have their result registered in the cycle after the transfer
//  a bank data write first runs ST_MOD: the remainder by the bank count
//  runs one bit per cycle through a single compare and subtract unit
//  the input is taken when idle and the output register is empty or being emptied
//  synchronous active-low reset; config writes are always taken
// ----------------------------------------------------------------------------
`default_nettype none

`include "bank_switch_mapper_with_scanline_irq_macros.svh"

module bank_switch_mapper_with_scanline_irq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [2:0]                   i_op,
    input  logic [bsm_pkg::ADDR_W-1:0]   i_address,
    input  logic [7:0]                   i_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [2:0]                   o_target,
    output logic [bsm_pkg::MAPPED_W-1:0] o_mapped_address,
    output logic                         o_chr_write_enable,
    output logic                         o_mirror_horizontal,
    output logic                         o_irq_line,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [2:0]                   i_cfg_index,
    input  logic [bsm_pkg::CFG_W-1:0]    i_cfg_data
);

    // configuration
    logic [6:0] r_prg_count;
    logic [8:0] r_chr_count;
    logic       r_chr_writable;
    logic [7:0] r_edge_gap;

    // mapper state
    bsm_pkg::t_state r_state, n_state;
    logic [7:0] r_sel, n_sel;
    logic [7:0] r_bank [0:7];
    logic [7:0] n_bank [0:7];
    logic       r_mirror, n_mirror;
    logic [7:0] r_latch, n_latch;
    logic [7:0] r_irq_cnt, n_irq_cnt;
    logic       r_reload, n_reload;
    logic       r_irq_en, n_irq_en;
    logic       r_irq_pend, n_irq_pend;
    logic       r_prev_a12, n_prev_a12;
    logic [7:0] r_cse, n_cse;

    // remainder unit
    logic [bsm_pkg::STEP_W-1:0] r_step, n_step;
    logic [7:0] r_val, n_val;
    logic [7:0] r_rem, n_rem;
    logic [8:0] r_den, n_den;
    logic [2:0] r_idx, n_idx;
    logic [8:0] w_div_t;
    logic       w_div_ge;
    logic [7:0] w_div_rem;

    // result register
    logic                         r_out_valid, n_out_valid;
    logic [2:0]                   r_tgt, n_tgt;
    logic [bsm_pkg::MAPPED_W-1:0] r_map, n_map;
    logic                         r_wen, n_wen;
    logic                         r_res_mirror, n_res_mirror;
    logic                         r_res_irq, n_res_irq;

    logic       w_in_fire;
    logic       w_emit;
    logic       w_bank_wr;
    logic [5:0] w_prg_bank;
    logic [2:0] w_chr_region;
    logic [8:0] w_chr_bank;
    logic [7:0] w_cse_inc;
    logic       w_a12;
    logic [7:0] w_bank_v;
    logic       w_small_idx;
    logic       w_chr_idx;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == bsm_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_fire   = i_in_valid && o_in_ready;

    assign o_out_valid         = r_out_valid;
    assign o_target            = r_tgt;
    assign o_mapped_address    = r_map;
    assign o_chr_write_enable  = r_wen;
    assign o_mirror_horizontal = r_res_mirror;
    assign o_irq_line          = r_res_irq;

    // prg bank for the cpu window
    always_comb begin
        unique case (i_address[14:13])
            2'd0:    w_prg_bank = r_sel[6] ? 6'(r_prg_count - 7'd2) : r_bank[6][5:0];
            2'd1:    w_prg_bank = r_bank[7][5:0];
            2'd2:    w_prg_bank = r_sel[6] ? r_bank[6][5:0] : 6'(r_prg_count - 7'd2);
            default: w_prg_bank = 6'(r_prg_count - 7'd1);
        endcase
    end

    // chr bank, 2 KiB pairs in the low half after inversion
    assign w_chr_region = i_address[12:10] ^ {r_sel[7], 2'b00};
    always_comb begin
        if (!w_chr_region[2]) begin
            w_chr_bank = {1'b0, r_bank[{2'b00, w_chr_region[1]}]}
                       + {8'd0, w_chr_region[0]};
        end else begin
            w_chr_bank = {1'b0, r_bank[{1'b0, w_chr_region[1:0]} + 3'd2]};
        end
    end

    assign w_cse_inc = (r_cse != 8'hFF) ? r_cse + 8'd1 : r_cse;
    assign w_a12     = i_address[12];

    // bank data operand, pair registers drop bit 0, prg registers keep six bits
    assign w_small_idx = (r_sel[2:0] <= 3'd1);
    assign w_chr_idx   = (r_sel[2:0] <= 3'd5);
    assign w_bank_v    = i_data & (w_small_idx ? 8'hFE : 8'hFF)
                                & (w_chr_idx ? 8'hFF : 8'h3F);
    assign w_bank_wr   = (i_op == bsm_pkg::OP_CPU_WRITE) && i_address[15]
                      && (i_address[14:13] == bsm_pkg::REG_BANK) && i_address[0];

    // shared compare and subtract
    assign w_div_t   = {r_rem, r_val[7]};
    assign w_div_ge  = (w_div_t >= r_den);
    assign w_div_rem = w_div_ge ? 8'(w_div_t - r_den) : w_div_t[7:0];

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_bank      = r_bank;
        n_mirror    = r_mirror;
        n_latch     = r_latch;
        n_irq_cnt   = r_irq_cnt;
        n_reload    = r_reload;
        n_irq_en    = r_irq_en;
        n_irq_pend  = r_irq_pend;
        n_prev_a12  = r_prev_a12;
        n_cse       = r_cse;
        n_step      = r_step;
        n_val       = r_val;
        n_rem       = r_rem;
        n_den       = r_den;
        n_idx       = r_idx;
        n_tgt       = r_tgt;
        n_map       = r_map;
        n_wen       = r_wen;
        n_out_valid = r_out_valid && !i_out_ready;
        w_emit      = 1'b0;

        unique case (r_state)
            bsm_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    w_emit = 1'b1;
                    n_tgt  = bsm_pkg::TGT_NONE;
                    n_map  = '0;
                    n_wen  = 1'b0;
                    unique case (i_op)
                        bsm_pkg::OP_CPU_READ, bsm_pkg::OP_CPU_WRITE: begin
                            if (i_address[15]) begin
                                if (i_op == bsm_pkg::OP_CPU_READ) begin
                                    n_tgt = bsm_pkg::TGT_PRG_ROM;
                                    n_map = {w_prg_bank, i_address[12:0]};
                                end else begin
                                    unique case (i_address[14:13])
                                        bsm_pkg::REG_BANK: begin
                                            if (!i_address[0]) begin
                                                n_sel = i_data;
                                            end else begin
                                                // remainder runs in ST_MOD
                                                w_emit  = 1'b0;
                                                n_state = bsm_pkg::ST_MOD;
                                                n_val   = w_bank_v;
                                                n_rem   = '0;
                                                n_step  = '0;
                                                n_idx   = r_sel[2:0];
                                                n_den   = w_chr_idx ? r_chr_count
                                                                    : {2'b00, r_prg_count};
                                            end
                                        end
                                        bsm_pkg::REG_MIRROR: begin
                                            if (!i_address[0]) begin
                                                n_mirror = i_data[0];
                                            end
                                        end
                                        bsm_pkg::REG_LATCH: begin
                                            if (!i_address[0]) begin
                                                n_latch = i_data;
                                            end else begin
                                                n_reload = 1'b1;
                                            end
                                        end
                                        default: begin
                                            if (!i_address[0]) begin
                                                n_irq_en   = 1'b0;
                                                n_irq_pend = 1'b0;
                                            end else begin
                                                n_irq_en = 1'b1;
                                            end
                                        end
                                    endcase
                                end
                            end else if (i_address[14:13] == 2'b11) begin
                                n_tgt = bsm_pkg::TGT_PRG_RAM;
                                n_map = {6'd0, i_address[12:0]};
                            end
                        end
                        bsm_pkg::OP_PPU_READ, bsm_pkg::OP_PPU_WRITE: begin
                            if (i_address[15:13] == 3'd0) begin
                                n_tgt = bsm_pkg::TGT_CHR;
                                n_map = {w_chr_bank, i_address[9:0]};
                                n_wen = (i_op == bsm_pkg::OP_PPU_WRITE) && r_chr_writable;
                            end else if (i_address[15:12] == 4'h2) begin
                                n_tgt = bsm_pkg::TGT_NAMETAB;
                                n_map = {3'd0, i_address};
                            end
                        end
                        bsm_pkg::OP_PPU_TICK: begin
                            n_cse = w_cse_inc;
                            if (w_a12 && !r_prev_a12) begin
                                if (w_cse_inc >= r_edge_gap) begin
                                    if ((r_irq_cnt == 8'd0) || r_reload) begin
                                        n_irq_cnt = r_latch;
                                        n_reload  = 1'b0;
                                    end else begin
                                        n_irq_cnt = r_irq_cnt - 8'd1;
                                    end
                                    if ((n_irq_cnt == 8'd0) && r_irq_en) begin
                                        n_irq_pend = 1'b1;
                                    end
                                end
                                n_cse = 8'd0;
                            end
                            n_prev_a12 = w_a12;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_rem  = w_div_rem;
                n_val  = {r_val[6:0], 1'b0};
                n_step = r_step + 1'b1;
                if (r_step == bsm_pkg::STEP_LAST) begin
                    // zero bank count maps to bank 0
                    n_bank[r_idx] = (r_den == 9'd0) ? 8'd0 : w_div_rem;
                    n_state       = bsm_pkg::ST_IDLE;
                    w_emit        = 1'b1;
                    n_tgt         = bsm_pkg::TGT_NONE;
                    n_map         = '0;
                    n_wen         = 1'b0;
                end
            end
        endcase

        if (w_emit) begin
            n_out_valid = 1'b1;
        end
        n_res_mirror = w_emit ? n_mirror : r_res_mirror;
        n_res_irq    = w_emit ? n_irq_pend : r_res_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_count    <= bsm_pkg::PRG_COUNT_RST;
            r_chr_count    <= bsm_pkg::CHR_COUNT_RST;
            r_chr_writable <= 1'b0;
            r_edge_gap     <= bsm_pkg::EDGE_GAP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            // default mirroring index is ignored; reset always loads the package default
            unique case (i_cfg_index)
                bsm_pkg::CFG_PRG_COUNT:   r_prg_count    <= i_cfg_data[6:0];
                bsm_pkg::CFG_CHR_COUNT:   r_chr_count    <= i_cfg_data;
                bsm_pkg::CFG_CHR_WRITE:   r_chr_writable <= i_cfg_data[0];
                bsm_pkg::CFG_EDGE_GAP:    r_edge_gap     <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsm_pkg::ST_IDLE;
            r_sel       <= '0;
            r_bank      <= '{default: 8'd0};
            r_mirror    <= bsm_pkg::DEFAULT_HOR_RST;
            r_latch     <= '0;
            r_irq_cnt   <= '0;
            r_reload    <= 1'b0;
            r_irq_en    <= 1'b0;
            r_irq_pend  <= 1'b0;
            r_prev_a12  <= 1'b0;
            r_cse       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_bank      <= n_bank;
            r_mirror    <= n_mirror;
            r_latch     <= n_latch;
            r_irq_cnt   <= n_irq_cnt;
            r_reload    <= n_reload;
            r_irq_en    <= n_irq_en;
            r_irq_pend  <= n_irq_pend;
            r_prev_a12  <= n_prev_a12;
            r_cse       <= n_cse;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_val        <= n_val;
        r_rem        <= n_rem;
        r_den        <= n_den;
        r_idx        <= n_idx;
        r_tgt        <= n_tgt;
        r_map        <= n_map;
        r_wen        <= n_wen;
        r_res_mirror <= n_res_mirror;
        r_res_irq    <= n_res_irq;
    end

    `BSM_ASSERT_IMP(a_busy_not_ready, r_state == bsm_pkg::ST_MOD, !o_in_ready,
                    "ready while busy")
    `BSM_ASSERT_NXT(a_bank_wr_to_mod, w_in_fire && w_bank_wr,
                    (r_state == bsm_pkg::ST_MOD) && !o_out_valid,
                    "bank write did not start remainder")
    `BSM_ASSERT_IMP(a_none_zero_addr, o_out_valid && (o_target == bsm_pkg::TGT_NONE),
                    o_mapped_address == '0, "nonzero address without target")
    `BSM_ASSERT_IMP(a_wen_chr_only, o_out_valid && o_chr_write_enable,
                    o_target == bsm_pkg::TGT_CHR, "write enable outside chr")

endmodule

`default_nettype wire

// ----- bench/bank_switch_mapper_with_scanline_irq_test.sv -----
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_scanline_irq_test
// self-checking bench for the bank switch mapper: a short table of directed
// accesses, then random cpu, ppu and tick traffic under several bank count
// and edge filter settings, every result checked in order against a local
// model of the bank registers and the a12 scanline counter
// ----------------------------------------------------------------------------
module bank_switch_mapper_with_scanline_irq_test;

    localparam int CLOCK_LIMIT      = 250000;
    localparam int RANDOM_PER_PHASE = 75;
    localparam int PHASES           = 6;
    localparam int DRAIN_CYCLES     = 16;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int MAX_REPORTS      = 10;
    localparam int DIRECTED_ROWS    = 26;

    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam logic [bsm_pkg::ADDR_W-1:0] CPU_RAM_BASE = 16'h6000;
    localparam logic [bsm_pkg::ADDR_W-1:0] CPU_REG_BASE = 16'h8000;
    localparam logic [bsm_pkg::ADDR_W-1:0] PPU_NT_BASE  = 16'h2000;
    localparam logic [bsm_pkg::ADDR_W-1:0] PPU_TOP_BASE = 16'h3000;

    typedef struct packed {
        logic [2:0]                   target;
        logic [bsm_pkg::MAPPED_W-1:0] mapped;
        logic                         chr_wen;
        logic                         mirror_h;
        logic                         irq;
    } t_map_result;

    typedef struct packed {
        logic [2:0]                 op;
        logic [bsm_pkg::ADDR_W-1:0] addr;
        logic [7:0]                 data;
        logic                       fixed_exp;
        t_map_result                res;
    } t_bus_row;

    localparam t_map_result NO_RES = '0;

    // expected values typed in only where they follow directly from reset
    localparam t_bus_row DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{bsm_pkg::OP_CPU_READ,  16'h0000, 8'h00, 1'b1,
          '{bsm_pkg::TGT_NONE,    19'h00000, 1'b0, 1'b1, 1'b0}},
        '{bsm_pkg::OP_CPU_READ,  16'h6000, 8'h00, 1'b1,
          '{bsm_pkg::TGT_PRG_RAM, 19'h00000, 1'b0, 1'b1, 1'b0}},
        '{bsm_pkg::OP_CPU_WRITE, 16'h7FFF, 8'hAA, 1'b1,
          '{bsm_pkg::TGT_PRG_RAM, 19'h01FFF, 1'b0, 1'b1, 1'b0}},
        '{bsm_pkg::OP_CPU_READ,  16'hFFFF, 8'h00, 1'b1,
          '{bsm_pkg::TGT_PRG_ROM, 19'h0FFFF, 1'b0, 1'b1, 1'b0}},
        '{bsm_pkg::OP_CPU_READ,  16'h8000, 8'h00, 1'b1,
          '{bsm_pkg::TGT_PRG_ROM, 19'h00000, 1'b0, 1'b1, 1'b0}},
        '{bsm_pkg::OP_PPU_READ,  16'h2000, 8'h00, 1'b1,
          '{bsm_pkg::TGT_NAMETAB, 19'h02000, 1'b0, 1'b1, 1'b0}},
        '{bsm_pkg::OP_PPU_READ,  16'h3000, 8'h00, 1'b1,
          '{bsm_pkg::TGT_NONE,    19'h00000, 1'b0, 1'b1, 1'b0}},
        '{bsm_pkg::OP_PPU_WRITE, 16'h1FFF, 8'h00, 1'b1,
          '{bsm_pkg::TGT_CHR,     19'h003FF, 1'b0, 1'b1, 1'b0}},
        '{OP_UNUSED,             16'hFFFF, 8'hFF, 1'b1,
          '{bsm_pkg::TGT_NONE,    19'h00000, 1'b0, 1'b1, 1'b0}},
        '{bsm_pkg::OP_PPU_TICK,  16'h1000, 8'h00, 1'b1,
          '{bsm_pkg::TGT_NONE,    19'h00000, 1'b0, 1'b1, 1'b0}},
        '{bsm_pkg::OP_CPU_WRITE, 16'hA000, 8'h00, 1'b1,
          '{bsm_pkg::TGT_NONE,    19'h00000, 1'b0, 1'b0, 1'b0}},
        '{bsm_pkg::OP_CPU_WRITE, 16'hA001, 8'h01, 1'b1,
          '{bsm_pkg::TGT_NONE,    19'h00000, 1'b0, 1'b0, 1'b0}},
        '{bsm_pkg::OP_CPU_WRITE, 16'h8000, 8'hC7, 1'b0, NO_RES},
        '{bsm_pkg::OP_CPU_WRITE, 16'h8001, 8'hFF, 1'b0, NO_RES},
        '{bsm_pkg::OP_CPU_READ,  16'h8000, 8'h00, 1'b0, NO_RES},
        '{bsm_pkg::OP_PPU_READ,  16'h0000, 8'h00, 1'b0, NO_RES},
        '{bsm_pkg::OP_PPU_WRITE, 16'h2FFF, 8'h5A, 1'b0, NO_RES},
        '{bsm_pkg::OP_CPU_WRITE, 16'h8000, 8'h00, 1'b0, NO_RES},
        '{bsm_pkg::OP_CPU_WRITE, 16'h9FFF, 8'hFF, 1'b0, NO_RES},
        '{bsm_pkg::OP_PPU_READ,  16'h0400, 8'h00, 1'b0, NO_RES},
        '{bsm_pkg::OP_CPU_WRITE, 16'hC000, 8'h00, 1'b0, NO_RES},
        '{bsm_pkg::OP_CPU_WRITE, 16'hC001, 8'h00, 1'b0, NO_RES},
        '{bsm_pkg::OP_CPU_WRITE, 16'hE001, 8'h00, 1'b0, NO_RES},
        '{bsm_pkg::OP_PPU_TICK,  16'h0000, 8'h00, 1'b0, NO_RES},
        '{bsm_pkg::OP_PPU_TICK,  16'hFFFF, 8'h00, 1'b0, NO_RES},
        '{bsm_pkg::OP_CPU_WRITE, 16'hE000, 8'h00, 1'b0, NO_RES}
    };

    logic                           i_clk               = 1'b0;
    logic                           i_rst_n             = 1'b0;
    logic                           i_in_valid          = 1'b0;
    logic                           o_in_ready;
    logic [2:0]                     i_op                = bsm_pkg::OP_CPU_READ;
    logic [bsm_pkg::ADDR_W-1:0]     i_address           = '0;
    logic [7:0]                     i_data              = '0;
    logic                           o_out_valid;
    logic                           i_out_ready         = 1'b0;
    logic [2:0]                     o_target;
    logic [bsm_pkg::MAPPED_W-1:0]   o_mapped_address;
    logic                           o_chr_write_enable;
    logic                           o_mirror_horizontal;
    logic                           o_irq_line;
    logic                           i_cfg_valid         = 1'b0;
    logic                           o_cfg_ready;
    logic [2:0]                     i_cfg_index         = bsm_pkg::CFG_PRG_COUNT;
    logic [bsm_pkg::CFG_W-1:0]      i_cfg_data          = '0;

    bank_switch_mapper_with_scanline_irq u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_op                (i_op),
        .i_address           (i_address),
        .i_data              (i_data),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_target            (o_target),
        .o_mapped_address    (o_mapped_address),
        .o_chr_write_enable  (o_chr_write_enable),
        .o_mirror_horizontal (o_mirror_horizontal),
        .o_irq_line          (o_irq_line),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // mapper model: configuration copy and mapper state
    logic [6:0]  cfg_prg_count;
    logic [8:0]  cfg_chr_count;
    logic        cfg_default_hor;
    logic        cfg_chr_write;
    logic [7:0]  cfg_edge_gap;

    logic [7:0]  sel_reg;
    logic [7:0]  bank_reg [8];
    logic        mirror_hor;
    logic [7:0]  scan_latch;
    logic [7:0]  scan_count;
    logic        reload_req;
    logic        irq_armed;
    logic        irq_flag;
    logic        a12_last;
    logic [7:0]  ticks_since_rise;

    t_map_result pending_maps [$];
    int          mismatch_count = 0;
    int          results_seen   = 0;
    bit          send_burst     = 1'b0;

    function automatic int unsigned reduce_bank(input int unsigned v, input int unsigned count);
        return (count == 0) ? 0 : v % count;
    endfunction

    // advances the mapper state by one access and returns what it maps to
    function automatic t_map_result map_access(input logic [2:0] op,
                                               input logic [bsm_pkg::ADDR_W-1:0] addr,
                                               input logic [7:0] data);
        t_map_result res;
        int unsigned bank;
        int unsigned v;
        logic [2:0]  slot;
        logic [5:0]  second_last;
        res = '0;
        case (op)
            bsm_pkg::OP_CPU_READ, bsm_pkg::OP_CPU_WRITE: begin
                if (addr >= CPU_REG_BASE && op == bsm_pkg::OP_CPU_READ) begin
                    // fixed banks wrap into six bits
                    second_last = 6'(cfg_prg_count - 7'd2);
                    case (addr[14:13])
                        2'd0:    bank = sel_reg[6] ? second_last : bank_reg[6];
                        2'd1:    bank = bank_reg[7];
                        2'd2:    bank = sel_reg[6] ? bank_reg[6] : second_last;
                        default: bank = 6'(cfg_prg_count - 7'd1);
                    endcase
                    res.target = bsm_pkg::TGT_PRG_ROM;
                    res.mapped = bsm_pkg::MAPPED_W'((bank << 13) + addr[12:0]);
                end else if (addr >= CPU_REG_BASE) begin
                    case (addr[14:13])
                        bsm_pkg::REG_BANK: begin
                            if (!addr[0]) begin
                                sel_reg = data;
                            end else begin
                                slot = sel_reg[2:0];
                                v = data;
                                if (slot <= 3'd1) v = v & 8'b11111110;
                                if (slot <= 3'd5) v = reduce_bank(v, cfg_chr_count);
                                else v = reduce_bank(v & 8'b00111111, cfg_prg_count);
                                bank_reg[slot] = 8'(v);
                            end
                        end
                        bsm_pkg::REG_MIRROR: begin
                            if (!addr[0]) mirror_hor = data[0];
                        end
                        bsm_pkg::REG_LATCH: begin
                            if (!addr[0]) scan_latch = data;
                            else reload_req = 1'b1;
                        end
                        default: begin
                            if (!addr[0]) begin
                                irq_armed = 1'b0;
                                irq_flag  = 1'b0;
                            end else begin
                                irq_armed = 1'b1;
                            end
                        end
                    endcase
                end else if (addr >= CPU_RAM_BASE) begin
                    res.target = bsm_pkg::TGT_PRG_RAM;
                    res.mapped = bsm_pkg::MAPPED_W'(addr - CPU_RAM_BASE);
                end
            end
            bsm_pkg::OP_PPU_READ, bsm_pkg::OP_PPU_WRITE: begin
                if (addr < PPU_NT_BASE) begin
                    slot = addr[12:10];
                    if (sel_reg[7]) slot[2] = ~slot[2];
                    // low half uses two 2 KiB pairs, high half four single banks
                    if (!slot[2]) bank = bank_reg[slot >> 1] + slot[0];
                    else bank = bank_reg[slot - 3'd2];
                    res.target  = bsm_pkg::TGT_CHR;
                    res.mapped  = bsm_pkg::MAPPED_W'((bank << 10) + addr[9:0]);
                    res.chr_wen = (op == bsm_pkg::OP_PPU_WRITE) && cfg_chr_write;
                end else if (addr < PPU_TOP_BASE) begin
                    res.target = bsm_pkg::TGT_NAMETAB;
                    res.mapped = bsm_pkg::MAPPED_W'(addr);
                end
            end
            bsm_pkg::OP_PPU_TICK: begin
                if (ticks_since_rise != 8'hFF) ticks_since_rise++;
                if (addr[12] && !a12_last) begin
                    if (ticks_since_rise >= cfg_edge_gap) begin
                        if (scan_count == 8'd0 || reload_req) begin
                            scan_count = scan_latch;
                            reload_req = 1'b0;
                        end else begin
                            scan_count = scan_count - 8'd1;
                        end
                        if (scan_count == 8'd0 && irq_armed) irq_flag = 1'b1;
                    end
                    ticks_since_rise = '0;
                end
                a12_last = addr[12];
            end
            default: ;
        endcase
        res.mirror_h = mirror_hor;
        res.irq      = irq_flag;
        return res;
    endfunction

    task automatic flag_mismatch(input string why, input t_map_result want,
                                 input t_map_result got);
        if (mismatch_count < MAX_REPORTS) begin
            $display("mismatch, %s: expected target %0d addr %05h wen %0b mirror %0b irq %0b,",
                     why, want.target, want.mapped, want.chr_wen, want.mirror_h, want.irq,
                     " got target %0d addr %05h wen %0b mirror %0b irq %0b",
                     got.target, got.mapped, got.chr_wen, got.mirror_h, got.irq);
        end
        mismatch_count++;
    endtask

    task automatic send_item(input t_bus_row row);
        int          gap;
        int          r;
        t_map_result predicted;
        r = $urandom_range(0, 99);
        if (send_burst || r < 50) gap = 0;
        else if (r < 85) gap = $urandom_range(1, 3);
        else if (r < 97) gap = $urandom_range(4, 10);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= row.op;
        i_address  <= row.addr;
        i_data     <= row.data;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = map_access(row.op, row.addr, row.data);
        pending_maps.push_back(row.fixed_exp ? row.res : predicted);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_maps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [bsm_pkg::CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            bsm_pkg::CFG_PRG_COUNT:   cfg_prg_count   = value[6:0];
            bsm_pkg::CFG_CHR_COUNT:   cfg_chr_count   = value[8:0];
            bsm_pkg::CFG_DEFAULT_HOR: cfg_default_hor = value[0];
            bsm_pkg::CFG_CHR_WRITE:   cfg_chr_write   = value[0];
            bsm_pkg::CFG_EDGE_GAP:    cfg_edge_gap    = value[7:0];
            default: ;
        endcase
    endtask

    // default mirroring is never stored by the mapper, so it has no visible effect
    task automatic apply_settings(input logic [6:0] prg, input logic [8:0] chr,
                                  input logic def_hor, input logic chr_wr,
                                  input logic [7:0] gap);
        write_cfg(bsm_pkg::CFG_PRG_COUNT, bsm_pkg::CFG_W'(prg));
        write_cfg(bsm_pkg::CFG_CHR_COUNT, bsm_pkg::CFG_W'(chr));
        write_cfg(bsm_pkg::CFG_DEFAULT_HOR, bsm_pkg::CFG_W'(def_hor));
        write_cfg(bsm_pkg::CFG_CHR_WRITE, bsm_pkg::CFG_W'(chr_wr));
        write_cfg(bsm_pkg::CFG_EDGE_GAP, bsm_pkg::CFG_W'(gap));
        i_cfg_valid <= 1'b0;
    endtask

    // result check, in order of transfer
    always @(posedge i_clk) begin : check_results
        t_map_result want;
        t_map_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_target, o_mapped_address, o_chr_write_enable,
                   o_mirror_horizontal, o_irq_line};
            results_seen <= results_seen + 1;
            if (pending_maps.size() == 0) begin
                flag_mismatch("result with nothing outstanding", NO_RES, got);
            end else begin
                want = pending_maps.pop_front();
                if (got.target !== want.target || got.mapped !== want.mapped ||
                    got.chr_wen !== want.chr_wen || got.mirror_h !== want.mirror_h ||
                    got.irq !== want.irq) begin
                    flag_mismatch("wrong result", want, got);
                end
            end
        end
    end

    // result side back-pressure, with one long hold once traffic is flowing
    int ready_stall     = 0;
    int ready_mode_left = 0;
    bit ready_burst     = 1'b0;
    bit long_hold_done  = 1'b0;

    always @(posedge i_clk) begin
        if (ready_mode_left == 0) begin
            ready_burst     <= ($urandom_range(0, 3) == 0);
            ready_mode_left <= $urandom_range(20, 120);
        end else begin
            ready_mode_left <= ready_mode_left - 1;
        end
        if (ready_stall > 0) begin
            ready_stall <= ready_stall - 1;
            i_out_ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 150) begin
            long_hold_done <= 1'b1;
            ready_stall    <= LONG_HOLD_CYCLES;
            i_out_ready    <= 1'b0;
        end else if (ready_burst || $urandom_range(0, 99) < 65) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= 1'b0;
            ready_stall <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50)
                                                        : $urandom_range(0, 3);
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CLOCK_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        t_bus_row   row;
        int         phase;
        int         n;
        int         k;
        int         r;
        int         pick;
        logic [1:0] win;
        bit         tick_a12;
        int         tick_run;
        tick_a12 = 1'b0;
        tick_run = 0;

        cfg_prg_count    = bsm_pkg::PRG_COUNT_RST;
        cfg_chr_count    = bsm_pkg::CHR_COUNT_RST;
        cfg_default_hor  = bsm_pkg::DEFAULT_HOR_RST;
        cfg_chr_write    = 1'b0;
        cfg_edge_gap     = bsm_pkg::EDGE_GAP_RST;
        sel_reg          = '0;
        bank_reg         = '{default: '0};
        mirror_hor       = bsm_pkg::DEFAULT_HOR_RST;
        scan_latch       = '0;
        scan_count       = '0;
        reload_req       = 1'b0;
        irq_armed        = 1'b0;
        irq_flag         = 1'b0;
        a12_last         = 1'b0;
        ticks_since_rise = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DIRECTED_ROWS; k++) send_item(DIRECTED[k]);
        wait_for_results();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: apply_settings(7'd2, 9'd1, 1'b0, 1'b1, 8'd0);
                1: apply_settings(7'd64, 9'd256, 1'b1, 1'b0, 8'd255);
                2: apply_settings(7'd0, 9'd0, 1'b0, 1'b1, 8'd1);
                3: apply_settings(7'd127, 9'd300, 1'b1, 1'b1, 8'd3);
                4: apply_settings(7'd1, 9'd255, 1'b0, 1'b0, 8'd9);
                default: apply_settings(7'($urandom_range(2, 64)), 9'($urandom_range(1, 256)),
                                        1'($urandom), 1'($urandom),
                                        8'($urandom_range(0, 20)));
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n % 25 == 0) send_burst = ($urandom_range(0, 2) == 0);
                // sender pause: let everything in flight come back
                if (phase == 2 && n == RANDOM_PER_PHASE / 2) wait_for_results();

                row      = '0;
                row.addr = 16'($urandom);
                row.data = 8'($urandom);
                r        = $urandom_range(0, 99);
                if (r < 30) begin
                    row.op       = bsm_pkg::OP_CPU_WRITE;
                    win          = 2'($urandom);
                    row.addr[15] = 1'b1;
                    row.addr[14:13] = win;
                    // small latch values so the counter reaches zero often
                    if (win == bsm_pkg::REG_LATCH && $urandom_range(0, 3) != 0)
                        row.data = 8'($urandom_range(0, 6));
                end else if (r < 42) begin
                    row.op = bsm_pkg::OP_CPU_READ;
                end else if (r < 47) begin
                    row.op       = bsm_pkg::OP_CPU_WRITE;
                    row.addr[15] = 1'b0;
                end else if (r < 62) begin
                    row.op = $urandom_range(0, 1) ? bsm_pkg::OP_PPU_READ
                                                  : bsm_pkg::OP_PPU_WRITE;
                    pick   = $urandom_range(0, 19);
                    if (pick < 12) row.addr[15:13] = 3'b000;
                    else if (pick < 17) row.addr[15:12] = 4'h2;
                end else if (r < 95) begin
                    // a12 held in runs, like pattern fetches across a scanline
                    row.op = bsm_pkg::OP_PPU_TICK;
                    if (tick_run == 0) begin
                        tick_a12 = ~tick_a12;
                        tick_run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                               : $urandom_range(1, 12);
                    end
                    tick_run--;
                    row.addr[12] = tick_a12;
                end else begin
                    row.op = 3'($urandom_range(5, 7));
                end
                send_item(row);
            end
            wait_for_results();
        end

        if (mismatch_count == 0 && pending_maps.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
